[design/pal_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pal_pkg
// Shared types and constants for the positional array list.
// ----------------------------------------------------------------------------
package pal_pkg;

  localparam int CAPACITY = 256;
  localparam int ELEM_W   = 32;
  localparam int AW       = $clog2(CAPACITY);
  localparam int CW       = $clog2(CAPACITY + 1);

  typedef enum logic [1:0] {
    ACT_INSERT = 2'd0,
    ACT_DELETE = 2'd1,
    ACT_READ   = 2'd2,
    ACT_NONE   = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2,
    ST_EMPTY = 2'd3
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_MOVE  = 4'b0010,
    S_PLACE = 4'b0100,
    S_READ  = 4'b1000
  } state_t;

  typedef struct packed {
    logic [1:0]         action;
    logic [CW-1:0]      position;
    logic signed [31:0] value;
  } req_word_t;

  typedef struct packed {
    logic [1:0]         status;
    logic signed [31:0] read_value;
    logic [CW-1:0]      element_count;
  } rsp_word_t;

endpackage

[design/pal_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pal_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module pal_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[design/positional_array_list.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// positional_array_list
// Ordered list of signed words in one RAM with insert, delete and read.
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low; its result appears
// on rsp for one cycle with done high and must be taken then. Requests that
// fail, the unused action, an insert at the end and a delete of the last
// entry give their result in the cycle after the request. A read passes
// through S_READ to capture the registered RAM data. An insert or delete
// inside the list moves entries in S_MOVE, then an insert writes its value
// in S_PLACE; every moved entry passes once through the single RAM read
// port and once through its write port. The capacity limit may be written
// through cfg_we and cfg_data whenever no request is in flight.
module positional_array_list (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  input  pal_pkg::req_word_t  req,
  output logic                done,
  output pal_pkg::rsp_word_t  rsp,
  input  logic                cfg_we,
  input  logic [8:0]          cfg_data
);

  pal_pkg::state_t state, state_next;

  logic [pal_pkg::CW-1:0] count, count_next;
  logic [pal_pkg::CW-1:0] limit;
  logic [pal_pkg::CW-1:0] eff_limit;
  logic [pal_pkg::AW-1:0] rd_addr, rd_addr_next;
  logic [pal_pkg::CW-1:0] rd_left, rd_left_next;
  logic                   pend, pend_next;
  logic [pal_pkg::AW-1:0] tgt, tgt_next;
  logic                   is_ins, is_ins_next;
  logic [pal_pkg::AW-1:0] pos_r, pos_r_next;
  logic [31:0]            val_r, val_r_next;
  logic                   done_next;
  pal_pkg::rsp_word_t     rsp_next;

  logic                          ram_we;
  logic [pal_pkg::AW-1:0]        ram_waddr;
  logic [pal_pkg::ELEM_W-1:0]    ram_wdata;
  logic [pal_pkg::AW-1:0]        ram_raddr;
  logic [pal_pkg::ELEM_W-1:0]    ram_rdata;

  logic                   accept;
  logic [pal_pkg::CW-1:0] pos;

  pal_ram #(
    .WIDTH(pal_pkg::ELEM_W),
    .DEPTH(pal_pkg::CAPACITY)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  assign busy   = (state != pal_pkg::S_IDLE);
  assign accept = start && !busy;
  assign pos    = req.position;

  always_comb begin
    if (limit == '0) begin
      eff_limit = pal_pkg::CW'(1);
    end else if (limit > pal_pkg::CW'(pal_pkg::CAPACITY)) begin
      eff_limit = pal_pkg::CW'(pal_pkg::CAPACITY);
    end else begin
      eff_limit = limit;
    end
  end

  always_comb begin
    state_next   = state;
    count_next   = count;
    rd_addr_next = rd_addr;
    rd_left_next = rd_left;
    pend_next    = 1'b0;
    tgt_next     = tgt;
    is_ins_next  = is_ins;
    pos_r_next   = pos_r;
    val_r_next   = val_r;
    done_next    = 1'b0;
    rsp_next     = rsp;
    ram_we       = 1'b0;
    ram_waddr    = tgt;
    ram_wdata    = ram_rdata;
    ram_raddr    = rd_addr;

    unique case (state)
      pal_pkg::S_IDLE: begin
        ram_raddr = pos[pal_pkg::AW-1:0];
        if (accept) begin
          rsp_next.status        = pal_pkg::ST_OK;
          rsp_next.read_value    = '0;
          rsp_next.element_count = count;
          pos_r_next             = pos[pal_pkg::AW-1:0];
          val_r_next             = req.value;
          case (req.action)
            pal_pkg::ACT_INSERT: begin
              if (pos > count) begin
                rsp_next.status = pal_pkg::ST_RANGE;
                done_next       = 1'b1;
              end else if (count >= eff_limit) begin
                rsp_next.status = pal_pkg::ST_FULL;
                done_next       = 1'b1;
              end else if (pos == count) begin
                ram_we                 = 1'b1;
                ram_waddr              = pos[pal_pkg::AW-1:0];
                ram_wdata              = req.value;
                count_next             = count + 1'b1;
                rsp_next.element_count = count + 1'b1;
                done_next              = 1'b1;
              end else begin
                rd_addr_next = pal_pkg::AW'(count - 1'b1);
                rd_left_next = count - pos;
                is_ins_next  = 1'b1;
                state_next   = pal_pkg::S_MOVE;
              end
            end
            pal_pkg::ACT_DELETE: begin
              if (count == '0) begin
                rsp_next.status = pal_pkg::ST_EMPTY;
                done_next       = 1'b1;
              end else if (pos >= count) begin
                rsp_next.status = pal_pkg::ST_RANGE;
                done_next       = 1'b1;
              end else if (pos == count - 1'b1) begin
                count_next             = count - 1'b1;
                rsp_next.element_count = count - 1'b1;
                done_next              = 1'b1;
              end else begin
                rd_addr_next = pal_pkg::AW'(pos + 1'b1);
                rd_left_next = count - pos - 1'b1;
                is_ins_next  = 1'b0;
                state_next   = pal_pkg::S_MOVE;
              end
            end
            pal_pkg::ACT_READ: begin
              if (count == '0) begin
                rsp_next.status = pal_pkg::ST_EMPTY;
                done_next       = 1'b1;
              end else if (pos >= count) begin
                rsp_next.status = pal_pkg::ST_RANGE;
                done_next       = 1'b1;
              end else begin
                state_next = pal_pkg::S_READ;
              end
            end
            default: begin
              done_next = 1'b1;
            end
          endcase
        end
      end
      pal_pkg::S_MOVE: begin
        // each read feeds the write in the cycle after it
        if (rd_left != '0) begin
          pend_next    = 1'b1;
          tgt_next     = is_ins ? rd_addr + 1'b1 : rd_addr - 1'b1;
          rd_addr_next = is_ins ? rd_addr - 1'b1 : rd_addr + 1'b1;
          rd_left_next = rd_left - 1'b1;
        end
        if (pend) begin
          ram_we = 1'b1;
          if (rd_left == '0) begin
            if (is_ins) begin
              state_next = pal_pkg::S_PLACE;
            end else begin
              count_next             = count - 1'b1;
              rsp_next.element_count = count - 1'b1;
              done_next              = 1'b1;
              state_next             = pal_pkg::S_IDLE;
            end
          end
        end
      end
      pal_pkg::S_PLACE: begin
        ram_we                 = 1'b1;
        ram_waddr              = pos_r;
        ram_wdata              = val_r;
        count_next             = count + 1'b1;
        rsp_next.element_count = count + 1'b1;
        done_next              = 1'b1;
        state_next             = pal_pkg::S_IDLE;
      end
      pal_pkg::S_READ: begin
        rsp_next.read_value = ram_rdata;
        done_next           = 1'b1;
        state_next          = pal_pkg::S_IDLE;
      end
      default: begin
        state_next = pal_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= pal_pkg::S_IDLE;
      count <= '0;
      limit <= pal_pkg::CW'(pal_pkg::CAPACITY);
      pend  <= 1'b0;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      pend  <= pend_next;
      done  <= done_next;
      if (cfg_we) begin
        limit <= cfg_data;
      end
    end
    rd_addr <= rd_addr_next;
    rd_left <= rd_left_next;
    tgt     <= tgt_next;
    is_ins  <= is_ins_next;
    pos_r   <= pos_r_next;
    val_r   <= val_r_next;
    rsp     <= rsp_next;
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= pal_pkg::CW'(pal_pkg::CAPACITY))
    else $error("element count above capacity");

  a_count_moves_with_word: assert property (@(posedge clk) disable iff (rst)
    ($past(!rst) && count != $past(count)) |-> done)
    else $error("count changed without a result word");

  a_fail_reads_zero: assert property (@(posedge clk) disable iff (rst)
    (done && rsp.status != pal_pkg::ST_OK) |-> rsp.read_value == '0)
    else $error("failed request returned data");

  a_accept_progress: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> (done || busy))
    else $error("accepted word neither finished nor in flight");

  a_idle_no_pending: assert property (@(posedge clk) disable iff (rst)
    !busy |-> !pend)
    else $error("pending move while idle");

endmodule

[tb/sv/pal_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pal_checker
// Result checker for the positional array list.
// ----------------------------------------------------------------------------
// Watches the request, result and capacity register ports. Each accepted
// request word is run through a local copy of the list and its expected
// result word is queued. Each result word is compared field by field with
// the oldest queued word. The mismatch count, the number of result words
// still awaited and the number of words compared are handed to the top.
// ----------------------------------------------------------------------------
module pal_checker (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  logic                busy,
  input  pal_pkg::req_word_t  req,
  input  logic                done,
  input  pal_pkg::rsp_word_t  rsp,
  input  logic                cfg_we,
  input  logic [8:0]          cfg_data,
  output int unsigned         mismatches,
  output int unsigned         pending_words,
  output int unsigned         checked
);

  logic signed [pal_pkg::ELEM_W-1:0] list_mem [pal_pkg::CAPACITY];
  int unsigned                       held;
  logic [8:0]                        cap_limit;
  pal_pkg::rsp_word_t                predicted_rsp [$];

  function automatic pal_pkg::rsp_word_t apply_request(pal_pkg::req_word_t w);
    pal_pkg::rsp_word_t r;
    int unsigned        lim;
    int                 i;
    r   = '0;
    lim = (cap_limit == 0) ? 1 :
          ((cap_limit > pal_pkg::CAPACITY) ? pal_pkg::CAPACITY : cap_limit);
    case (pal_pkg::action_t'(w.action))
      pal_pkg::ACT_INSERT: begin
        if (w.position > held) begin
          r.status = pal_pkg::ST_RANGE;
        end else if (held >= lim) begin
          r.status = pal_pkg::ST_FULL;
        end else begin
          for (i = held; i > w.position; i--) list_mem[i] = list_mem[i-1];
          list_mem[w.position] = w.value;
          held++;
        end
      end
      pal_pkg::ACT_DELETE: begin
        if (held == 0) begin
          r.status = pal_pkg::ST_EMPTY;
        end else if (w.position >= held) begin
          r.status = pal_pkg::ST_RANGE;
        end else begin
          for (i = w.position; i + 1 < held; i++) list_mem[i] = list_mem[i+1];
          held--;
        end
      end
      pal_pkg::ACT_READ: begin
        if (held == 0) begin
          r.status = pal_pkg::ST_EMPTY;
        end else if (w.position >= held) begin
          r.status = pal_pkg::ST_RANGE;
        end else begin
          r.read_value = list_mem[w.position];
        end
      end
      default: begin
      end
    endcase
    r.element_count = held[pal_pkg::CW-1:0];
    return r;
  endfunction

  always @(posedge clk) begin
    pal_pkg::rsp_word_t want;
    if (rst) begin
      held       = 0;
      cap_limit  = 9'd256;
      mismatches = 0;
      checked    = 0;
      predicted_rsp.delete();
    end else begin
      if (done) begin
        if (predicted_rsp.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected result word: status %0d read %0d count %0d",
                     rsp.status, rsp.read_value, rsp.element_count);
        end else begin
          want = predicted_rsp.pop_front();
          checked++;
          if (rsp.status !== want.status || rsp.read_value !== want.read_value ||
              rsp.element_count !== want.element_count) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("result word %0d: expected status %0d read %0d count %0d",
                       checked, want.status, want.read_value, want.element_count);
              $display("result word %0d: got status %0d read %0d count %0d",
                       checked, rsp.status, rsp.read_value, rsp.element_count);
            end
          end
        end
      end
      if (start && !busy) predicted_rsp.push_back(apply_request(req));
      if (cfg_we) cap_limit = cfg_data;
    end
    pending_words <= predicted_rsp.size();
  end

endmodule

[tb/sv/tb_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Testbench for the positional array list.
// ----------------------------------------------------------------------------
// Drives a directed set of inserts, deletes and reads covering the empty,
// full and out of range cases, then random request words over several
// capacity settings, including a fill of the whole list. The checker beside
// the block predicts and compares every result word.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int unsigned QUIET_LIMIT = 4000;

  logic                clk;
  logic                rst;
  logic                start;
  logic                busy;
  pal_pkg::req_word_t  req;
  logic                done;
  pal_pkg::rsp_word_t  rsp;
  logic                cfg_we;
  logic [8:0]          cfg_data;

  int unsigned mismatches;
  int unsigned pending_words;
  int unsigned checked;
  int unsigned last_count;
  int unsigned quiet_cycles;
  int unsigned n_ins, n_del, n_rd, n_none, n_cfg;
  bit          calm;

  positional_array_list dut (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .busy     (busy),
    .req      (req),
    .done     (done),
    .rsp      (rsp),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data)
  );

  pal_checker checker_i (
    .clk           (clk),
    .rst           (rst),
    .start         (start),
    .busy          (busy),
    .req           (req),
    .done          (done),
    .rsp           (rsp),
    .cfg_we        (cfg_we),
    .cfg_data      (cfg_data),
    .mismatches    (mismatches),
    .pending_words (pending_words),
    .checked       (checked)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    if (done) last_count <= rsp.element_count;
  end

  always @(posedge clk) begin
    if (rst || done || (start && !busy)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  task automatic send_word(input pal_pkg::action_t act, input int unsigned pos,
                           input logic [31:0] val);
    start <= 1'b1;
    req   <= '{action: act, position: pos[pal_pkg::CW-1:0], value: val};
    @(posedge clk);
    while (busy) @(posedge clk);
    case (act)
      pal_pkg::ACT_INSERT: n_ins++;
      pal_pkg::ACT_DELETE: n_del++;
      pal_pkg::ACT_READ:   n_rd++;
      default:             n_none++;
    endcase
  endtask

  task automatic idle_gap();
    while (!calm && $urandom_range(0, 99) < 19) begin
      start <= 1'b0;
      @(posedge clk);
    end
  endtask

  task automatic drain();
    start <= 1'b0;
    do @(posedge clk); while (pending_words != 0 || busy);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_limit(input logic [8:0] lim);
    drain();
    cfg_we   <= 1'b1;
    cfg_data <= lim;
    @(posedge clk);
    cfg_we <= 1'b0;
    n_cfg++;
  endtask

  task automatic random_word(input int unsigned ins_pct);
    int unsigned      roll;
    int unsigned      len;
    int unsigned      pos;
    pal_pkg::action_t act;
    logic [31:0]      val;
    len  = last_count;
    roll = $urandom_range(0, 99);
    if (roll < 4) act = pal_pkg::ACT_NONE;
    else if (roll < 4 + ins_pct) act = pal_pkg::ACT_INSERT;
    else if (roll[0]) act = pal_pkg::ACT_DELETE;
    else act = pal_pkg::ACT_READ;
    roll = $urandom_range(0, 99);
    if (roll < 12) pos = $urandom_range(0, 511);
    else if (roll < 20) pos = 0;
    else if (act == pal_pkg::ACT_INSERT) pos = $urandom_range(0, len);
    else pos = (len == 0) ? 0 : $urandom_range(0, len - 1);
    case ($urandom_range(0, 7))
      0:       val = 32'h8000_0000;
      1:       val = 32'h7fff_ffff;
      2:       val = 32'hffff_ffff;
      3:       val = $urandom_range(0, 15);
      default: val = $urandom;
    endcase
    send_word(act, pos, val);
    idle_gap();
  endtask

  initial begin
    int unsigned k;
    rst        = 1'b1;
    start      = 1'b0;
    req        = '0;
    cfg_we     = 1'b0;
    cfg_data   = '0;
    last_count = 0;
    calm       = 1'b0;
    n_ins = 0; n_del = 0; n_rd = 0; n_none = 0; n_cfg = 0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // directed: empty list, ends, middle, out of range, unused action
    send_word(pal_pkg::ACT_READ,   0,   32'h0);
    send_word(pal_pkg::ACT_DELETE, 511, 32'h0);
    send_word(pal_pkg::ACT_INSERT, 1,   32'h1234_5678);
    send_word(pal_pkg::ACT_INSERT, 0,   32'h8000_0000);
    send_word(pal_pkg::ACT_INSERT, 1,   32'h7fff_ffff);
    send_word(pal_pkg::ACT_INSERT, 0,   32'hffff_ffff);
    send_word(pal_pkg::ACT_INSERT, 2,   32'h0);
    send_word(pal_pkg::ACT_INSERT, 511, 32'hdead_beef);
    for (k = 0; k < 5; k++) send_word(pal_pkg::ACT_READ, k, 32'h0);
    send_word(pal_pkg::ACT_READ,   511, 32'h0);
    send_word(pal_pkg::ACT_NONE,   511, 32'hffff_ffff);
    send_word(pal_pkg::ACT_DELETE, 4,   32'h0);
    send_word(pal_pkg::ACT_DELETE, 1,   32'h0);
    send_word(pal_pkg::ACT_DELETE, 2,   32'h0);
    send_word(pal_pkg::ACT_DELETE, 0,   32'h0);
    send_word(pal_pkg::ACT_INSERT, 1,   32'h5a5a_a5a5);
    send_word(pal_pkg::ACT_READ,   1,   32'h0);

    // limit of zero acts as one, already below the count
    write_limit(9'd0);
    send_word(pal_pkg::ACT_INSERT, 0, 32'h0000_0001);
    repeat (15) random_word(30);

    write_limit(9'd1);
    repeat (30) random_word(40);

    write_limit(9'd2);
    repeat (40) random_word(45);

    write_limit(9'd17);
    repeat (80) random_word(55);

    // limit above the built capacity; fill the whole list with no idling
    write_limit(9'd511);
    drain();
    calm = 1'b1;
    for (k = last_count; k < pal_pkg::CAPACITY; k++) begin
      send_word(pal_pkg::ACT_INSERT, $urandom_range(0, k), $urandom);
    end
    repeat (6) send_word(pal_pkg::ACT_INSERT, $urandom_range(0, pal_pkg::CAPACITY), $urandom);
    send_word(pal_pkg::ACT_READ, pal_pkg::CAPACITY - 1, 32'h0);
    repeat (60) random_word(35);
    calm = 1'b0;

    // lowered below the current count
    write_limit(9'd8);
    repeat (90) random_word(20);

    write_limit(9'd256);
    repeat (60) random_word(50);

    drain();
    $display("covered %0d request words: %0d insert, %0d delete, %0d read, %0d unused",
             n_ins + n_del + n_rd + n_none, n_ins, n_del, n_rd, n_none);
    $display("%0d result words compared over %0d capacity settings, with one full fill",
             checked, n_cfg);
    if (mismatches == 0 && pending_words == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
